// File: src/mai_pkg.sv
// shared types and constants for the masked address index assigner
// no dependencies
package mai_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int KEY_W = 129;

	localparam int STATUS_W = 3;
	localparam int NET_INDEX_W = 10;
	localparam int ENTRY_COUNT_W = 11;
	localparam int CFG_INDEX_W = 2;

	localparam logic [STATUS_W-1:0] STAT_FOUND = 3'd0;
	localparam logic [STATUS_W-1:0] STAT_ADDED = 3'd1;
	localparam logic [STATUS_W-1:0] STAT_MALFORMED = 3'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL = 3'd3;
	localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

	localparam logic [CFG_INDEX_W-1:0] REG_V4_MASK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_V6_MASK_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_V6_MASK_LOW = 2'd2;

	localparam logic [31:0] V4_MASK_RST = 32'hFFFF_FF00;
	localparam logic [63:0] V6_MASK_HIGH_RST = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] V6_MASK_LOW_RST = 64'hFFFF_FFFF_0000_0000;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

// File: src/mai_req_if.sv
// request channel: one address word or clear command
// depends on nothing
interface mai_req_if;
	logic valid;
	logic ready;
	logic cmd;
	logic is_v6;
	logic [63:0] addr_high;
	logic [63:0] addr_low;
	logic malformed;

	modport source (output valid, cmd, is_v6, addr_high, addr_low, malformed, input ready);
	modport sink (input valid, cmd, is_v6, addr_high, addr_low, malformed, output ready);
endinterface

// File: src/mai_rsp_if.sv
// response channel: status, index and table fill per request word
// depends on nothing
interface mai_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [9:0] net_index;
	logic [10:0] entry_count;

	modport source (output valid, status, net_index, entry_count, input ready);
	modport sink (input valid, status, net_index, entry_count, output ready);
endinterface

// File: src/mai_cfg_if.sv
// configuration write channel: register index and data
// depends on nothing
interface mai_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [63:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/masked_address_index_assigner.sv
// masked address index assigner top level: key memory, linear search, result register
// depends on mai_pkg and the mai_req_if, mai_rsp_if, mai_cfg_if interfaces
//
// Each request word is accepted in the idle state. A lookup then visits the
// stored keys in order until it finds a match or passes the last one: the key
// memory is read one entry per cycle on its single read port. A clear, a
// malformed word or a lookup in an empty table skips the search. Keys are
// numbered in order of first appearance; a full table returns status full
// and stores nothing. No clearing pass is needed after reset.
module masked_address_index_assigner (
	input logic clk,
	input logic arst_n,
	mai_req_if.sink req,
	mai_rsp_if.source rsp,
	mai_cfg_if.sink cfg
);
	import mai_pkg::*;

	logic [31:0] v4_mask_q;
	logic [63:0] v6_mask_high_q;
	logic [63:0] v6_mask_low_q;

	state_t state_q, state_d;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [KEY_W-1:0] key_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [IDX_W-1:0] res_index_q;

	logic [KEY_W-1:0] mem [CAPACITY];
	logic [KEY_W-1:0] rdata_q;
	logic [IDX_W-1:0] rd_addr;
	logic mem_we;

	logic rsp_valid_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic [NET_INDEX_W-1:0] rsp_net_index_q;
	logic [ENTRY_COUNT_W-1:0] rsp_entry_count_q;

	logic req_fire;
	logic out_free;
	logic commit;
	logic is_full;
	logic hit;
	logic last;
	logic [KEY_W-1:0] key_d;
	logic [STATUS_W-1:0] miss_status;
	logic [IDX_W-1:0] miss_index;
	logic [CNT_W-1:0] count_next;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4_mask_q <= V4_MASK_RST;
			v6_mask_high_q <= V6_MASK_HIGH_RST;
			v6_mask_low_q <= V6_MASK_LOW_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_V4_MASK: v4_mask_q <= cfg.data[31:0];
				REG_V6_MASK_HIGH: v6_mask_high_q <= cfg.data;
				REG_V6_MASK_LOW: v6_mask_low_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// key layout: family, high half, low half
	always_comb begin
		if (req.is_v6) begin
			key_d = {1'b1, req.addr_high & v6_mask_high_q, req.addr_low & v6_mask_low_q};
		end else begin
			key_d = {1'b0, 64'd0, 32'd0, req.addr_low[31:0] & v4_mask_q};
		end
	end

	assign is_full = (count_q == CNT_W'(CAPACITY));
	assign miss_status = is_full ? STAT_FULL : STAT_ADDED;
	assign miss_index = is_full ? '0 : count_q[IDX_W-1:0];
	assign hit = (rdata_q == key_q);
	assign last = ({1'b0, idx_q} + (IDX_W+1)'(1)) >= (IDX_W+1)'(count_q);
	assign out_free = !rsp_valid_q || rsp.ready;
	assign req_fire = req.valid && req.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					if (req.cmd || req.malformed || count_q == '0) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit || last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		req.ready = (state_q == ST_IDLE);
		commit = (state_q == ST_DONE) && out_free;
		mem_we = commit && (res_status_q == STAT_ADDED);
		rd_addr = (state_q == ST_IDLE) ? '0 : idx_q + IDX_W'(1);
	end

	always_comb begin
		count_next = count_q;
		if (res_status_q == STAT_CLEARED) count_next = '0;
		else if (res_status_q == STAT_ADDED) count_next = count_q + CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[count_q[IDX_W-1:0]] <= key_q;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (commit) begin
				count_q <= count_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			key_q <= key_d;
			idx_q <= '0;
			res_index_q <= '0;
			if (req.cmd) begin
				res_status_q <= STAT_CLEARED;
			end else if (req.malformed) begin
				res_status_q <= STAT_MALFORMED;
			end else begin
				res_status_q <= miss_status;
				res_index_q <= miss_index;
			end
		end else if (state_q == ST_SCAN) begin
			if (hit) begin
				res_status_q <= STAT_FOUND;
				res_index_q <= idx_q;
			end else if (last) begin
				res_status_q <= miss_status;
				res_index_q <= miss_index;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
		if (commit) begin
			rsp_status_q <= res_status_q;
			rsp_net_index_q <= NET_INDEX_W'(res_index_q);
			rsp_entry_count_q <= ENTRY_COUNT_W'(count_next);
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.status = rsp_status_q;
	assign rsp.net_index = rsp_net_index_q;
	assign rsp.entry_count = rsp_entry_count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("stored count beyond capacity");

	a_scan_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> {1'b0, idx_q} < (IDX_W+1)'(count_q))
		else $error("search past last stored key");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("store without count increment");

	a_found_below_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == STAT_FOUND |->
			ENTRY_COUNT_W'(rsp_net_index_q) < rsp_entry_count_q)
		else $error("found index outside table");
`endif

endmodule
